@@ rtl/triangle_edge_rasterizer_macros.svh @@
// ----------------------------------------------------------------------------
// Triangle edge rasterizer assertion macros
// Shared concurrent assertion forms used by the rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_EDGE_RASTERIZER_MACROS_SVH
`define TRIANGLE_EDGE_RASTERIZER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TRE_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tre_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle edge rasterizer package
// Widths, transaction codes, payload and pipeline types, small helpers.
// ----------------------------------------------------------------------------
package tre_pkg;

    localparam int C_COORD_BITS = 12;
    localparam int C_DELTA_BITS = C_COORD_BITS + 1;
    localparam int C_PROD_BITS  = 2 * C_DELTA_BITS;
    localparam int C_EDGE_BITS  = C_PROD_BITS + 1;
    localparam int C_NUM_EDGES  = 3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    localparam logic [2:0] KIND_LOAD_OK     = 3'd0;
    localparam logic [2:0] KIND_LOAD_CULLED = 3'd1;
    localparam logic [2:0] KIND_COVERED     = 3'd2;
    localparam logic [2:0] KIND_OUTSIDE     = 3'd3;
    localparam logic [2:0] KIND_IDLE        = 3'd4;

    typedef logic signed [C_COORD_BITS-1:0] t_coord;
    typedef logic signed [C_DELTA_BITS-1:0] t_delta;
    typedef logic signed [C_PROD_BITS-1:0]  t_prod;
    typedef logic signed [C_EDGE_BITS-1:0]  t_edge;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_colour;

    typedef struct packed {
        logic       func;
        t_coord     ax;
        t_coord     ay;
        t_coord     bx;
        t_coord     by_coord;
        t_coord     cx;
        t_coord     cy;
        logic [2:0] behind_mask;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        t_coord     pixel_x;
        t_coord     pixel_y;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last;
    } t_out_item;

    // Setup stage result: box, per-edge slopes and corner offsets.
    typedef struct packed {
        logic                        func;
        logic                        cull;
        t_coord                      min_x;
        t_coord                      max_x;
        t_coord                      min_y;
        t_coord                      max_y;
        t_delta [C_NUM_EDGES-1:0]    ea;
        t_delta [C_NUM_EDGES-1:0]    eb;
        t_delta [C_NUM_EDGES-1:0]    ox;
        t_delta [C_NUM_EDGES-1:0]    oy;
        t_delta                      ac_x;
        t_delta                      ac_y;
        t_colour                     colour;
    } t_setup;

    // Product stage result: partial products of the corner edge values and area.
    typedef struct packed {
        logic                        func;
        logic                        cull;
        t_coord                      min_x;
        t_coord                      max_x;
        t_coord                      min_y;
        t_coord                      max_y;
        t_delta [C_NUM_EDGES-1:0]    ea;
        t_delta [C_NUM_EDGES-1:0]    eb;
        t_prod  [C_NUM_EDGES-1:0]    pa;
        t_prod  [C_NUM_EDGES-1:0]    pb;
        t_prod                       area_a;
        t_prod                       area_b;
        t_colour                     colour;
    } t_prodset;

    function automatic t_coord f_min3(input t_coord a, input t_coord b, input t_coord c);
        t_coord m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic t_coord f_max3(input t_coord a, input t_coord b, input t_coord c);
        t_coord m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

@@ rtl/tre_setup.sv @@
// ----------------------------------------------------------------------------
// Triangle edge rasterizer setup stage
// Bounding box, edge slopes and offsets of the box corner from each edge start.
// ----------------------------------------------------------------------------
module tre_setup import tre_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_setup   o_setup,
    input  logic     i_ready
);

    // Edge k runs from vertex C_EDGE_FROM[k] to vertex C_EDGE_TO[k].
    localparam int C_EDGE_FROM [C_NUM_EDGES] = '{1, 2, 0};
    localparam int C_EDGE_TO   [C_NUM_EDGES] = '{2, 0, 1};

    logic   r_valid;
    t_setup r_setup;
    t_setup n_setup;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_setup = r_setup;

    always_comb begin
        t_coord vx [C_NUM_EDGES];
        t_coord vy [C_NUM_EDGES];
        t_coord min_x;
        t_coord min_y;
        vx[0] = i_item.ax;
        vx[1] = i_item.bx;
        vx[2] = i_item.cx;
        vy[0] = i_item.ay;
        vy[1] = i_item.by_coord;
        vy[2] = i_item.cy;
        min_x = f_min3(vx[0], vx[1], vx[2]);
        min_y = f_min3(vy[0], vy[1], vy[2]);
        n_setup        = '0;
        n_setup.func   = i_item.func;
        n_setup.cull   = |i_item.behind_mask;
        n_setup.min_x  = min_x;
        n_setup.max_x  = f_max3(vx[0], vx[1], vx[2]);
        n_setup.min_y  = min_y;
        n_setup.max_y  = f_max3(vy[0], vy[1], vy[2]);
        for (int k = 0; k < C_NUM_EDGES; k++) begin
            n_setup.ea[k] = t_delta'(vy[C_EDGE_FROM[k]]) - t_delta'(vy[C_EDGE_TO[k]]);
            n_setup.eb[k] = t_delta'(vx[C_EDGE_TO[k]]) - t_delta'(vx[C_EDGE_FROM[k]]);
            n_setup.ox[k] = t_delta'(min_x) - t_delta'(vx[C_EDGE_FROM[k]]);
            n_setup.oy[k] = t_delta'(min_y) - t_delta'(vy[C_EDGE_FROM[k]]);
        end
        n_setup.ac_x   = t_delta'(i_item.cx) - t_delta'(i_item.ax);
        n_setup.ac_y   = t_delta'(i_item.cy) - t_delta'(i_item.ay);
        n_setup.colour = '{red: i_item.red_in, green: i_item.green_in, blue: i_item.blue_in};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_setup <= n_setup;
        end
    end

endmodule

@@ rtl/tre_mult.sv @@
// ----------------------------------------------------------------------------
// Triangle edge rasterizer product stage
// Multiplies slopes by corner offsets for every edge of the triangle and the area term.
// ----------------------------------------------------------------------------
module tre_mult import tre_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_setup   i_setup,
    output logic     o_valid,
    output t_prodset o_prod,
    input  logic     i_ready
);

    // Edge index of the A to B edge, whose function at C is the signed area.
    localparam int C_AREA_EDGE = 2;

    logic     r_valid;
    t_prodset r_prod;
    t_prodset n_prod;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    always_comb begin
        n_prod        = '0;
        n_prod.func   = i_setup.func;
        n_prod.cull   = i_setup.cull;
        n_prod.min_x  = i_setup.min_x;
        n_prod.max_x  = i_setup.max_x;
        n_prod.min_y  = i_setup.min_y;
        n_prod.max_y  = i_setup.max_y;
        n_prod.ea     = i_setup.ea;
        n_prod.eb     = i_setup.eb;
        n_prod.colour = i_setup.colour;
        for (int k = 0; k < C_NUM_EDGES; k++) begin
            n_prod.pa[k] = t_prod'($signed(i_setup.ea[k])) * t_prod'($signed(i_setup.ox[k]));
            n_prod.pb[k] = t_prod'($signed(i_setup.eb[k])) * t_prod'($signed(i_setup.oy[k]));
        end
        n_prod.area_a = t_prod'($signed(i_setup.ea[C_AREA_EDGE])) * t_prod'(i_setup.ac_x);
        n_prod.area_b = t_prod'($signed(i_setup.eb[C_AREA_EDGE])) * t_prod'(i_setup.ac_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

endmodule

@@ rtl/tre_core.sv @@
// ----------------------------------------------------------------------------
// Triangle edge rasterizer scan core
// Holds the triangle state, walks the box and drives the result register.
// ----------------------------------------------------------------------------
`include "triangle_edge_rasterizer_macros.svh"

module tre_core import tre_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_prodset  i_prod,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_ready
);

    logic      r_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic    r_active;
    logic    n_active;
    t_coord  r_cur_x, n_cur_x;
    t_coord  r_cur_y, n_cur_y;
    t_coord  r_min_x, n_min_x;
    t_coord  r_max_x, n_max_x;
    t_coord  r_max_y, n_max_y;
    t_colour r_colour, n_colour;
    t_edge   r_e_cur [C_NUM_EDGES];
    t_edge   n_e_cur [C_NUM_EDGES];
    t_edge   r_e_row [C_NUM_EDGES];
    t_edge   n_e_row [C_NUM_EDGES];
    t_delta  r_ea [C_NUM_EDGES];
    t_delta  n_ea [C_NUM_EDGES];
    t_delta  r_eb [C_NUM_EDGES];
    t_delta  n_eb [C_NUM_EDGES];

    logic w_fire;
    logic w_inside;
    logic w_end_row;
    logic w_fin;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_out;
    assign w_fire  = i_valid && o_ready;

    always_comb begin
        w_inside = 1'b1;
        for (int k = 0; k < C_NUM_EDGES; k++) begin
            w_inside = w_inside && (r_e_cur[k][C_EDGE_BITS-1] || (r_e_cur[k] == '0));
        end
        w_end_row = (r_cur_x >= r_max_x);
        w_fin     = w_end_row && (r_cur_y >= r_max_y);
    end

    always_comb begin
        t_edge area;
        t_edge e_load [C_NUM_EDGES];
        area = t_edge'($signed(i_prod.area_a)) + t_edge'($signed(i_prod.area_b));
        for (int k = 0; k < C_NUM_EDGES; k++) begin
            e_load[k] = t_edge'($signed(i_prod.pa[k])) + t_edge'($signed(i_prod.pb[k]));
        end
        n_out    = '0;
        n_active = r_active;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_min_x  = r_min_x;
        n_max_x  = r_max_x;
        n_max_y  = r_max_y;
        n_colour = r_colour;
        n_e_cur  = r_e_cur;
        n_e_row  = r_e_row;
        n_ea     = r_ea;
        n_eb     = r_eb;
        if (i_prod.func == FUNC_LOAD) begin
            if (i_prod.cull || !area[C_EDGE_BITS-1]) begin
                n_out.kind = KIND_LOAD_CULLED;
                n_active   = 1'b0;
            end else begin
                n_out.kind = KIND_LOAD_OK;
                n_active   = 1'b1;
                n_cur_x    = i_prod.min_x;
                n_cur_y    = i_prod.min_y;
                n_min_x    = i_prod.min_x;
                n_max_x    = i_prod.max_x;
                n_max_y    = i_prod.max_y;
                n_colour   = i_prod.colour;
                for (int k = 0; k < C_NUM_EDGES; k++) begin
                    n_e_cur[k] = e_load[k];
                    n_e_row[k] = e_load[k];
                    n_ea[k]    = $signed(i_prod.ea[k]);
                    n_eb[k]    = $signed(i_prod.eb[k]);
                end
            end
        end else if (!r_active) begin
            n_out.kind = KIND_IDLE;
        end else begin
            n_out.kind      = w_inside ? KIND_COVERED : KIND_OUTSIDE;
            n_out.pixel_x   = r_cur_x;
            n_out.pixel_y   = r_cur_y;
            n_out.red_out   = r_colour.red;
            n_out.green_out = r_colour.green;
            n_out.blue_out  = r_colour.blue;
            n_out.last      = w_fin;
            if (w_fin) begin
                n_active = 1'b0;
            end else if (w_end_row) begin
                n_cur_x = r_min_x;
                n_cur_y = r_cur_y + t_coord'(1);
                for (int k = 0; k < C_NUM_EDGES; k++) begin
                    n_e_row[k] = r_e_row[k] + t_edge'(r_eb[k]);
                    n_e_cur[k] = r_e_row[k] + t_edge'(r_eb[k]);
                end
            end else begin
                n_cur_x = r_cur_x + t_coord'(1);
                for (int k = 0; k < C_NUM_EDGES; k++) begin
                    n_e_cur[k] = r_e_cur[k] + t_edge'(r_ea[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_fire) begin
                r_active <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out    <= n_out;
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_min_x  <= n_min_x;
            r_max_x  <= n_max_x;
            r_max_y  <= n_max_y;
            r_colour <= n_colour;
            r_e_cur  <= n_e_cur;
            r_e_row  <= n_e_row;
            r_ea     <= n_ea;
            r_eb     <= n_eb;
        end
    end

    `TRE_ASSERT_HOLDS(a_cursor_in_box, i_clk, i_rst_n, r_active, (r_cur_x >= r_min_x) && (r_cur_x <= r_max_x) && (r_cur_y <= r_max_y), "scan cursor is outside the bounding box")
    `TRE_ASSERT_HOLDS(a_last_on_pixel, i_clk, i_rst_n, o_valid && o_item.last, (o_item.kind == KIND_COVERED) || (o_item.kind == KIND_OUTSIDE), "last flag on a result that is not a pixel")
    `TRE_ASSERT_NEXT(a_fin_clears_active, i_clk, i_rst_n, w_fire && (i_prod.func == FUNC_STEP) && r_active && w_fin, !r_active && o_valid && o_item.last, "final pixel did not end the box")
    `TRE_ASSERT_NEXT(a_load_sets_active, i_clk, i_rst_n, w_fire && (i_prod.func == FUNC_LOAD), o_valid && (r_active == (o_item.kind == KIND_LOAD_OK)) && ((o_item.kind == KIND_LOAD_OK) || (o_item.kind == KIND_LOAD_CULLED)), "load result and active flag disagree")

endmodule

@@ rtl/triangle_edge_rasterizer.sv @@
// ----------------------------------------------------------------------------
// Triangle edge rasterizer
// Culls and sets up a flat shaded triangle, then reports one box pixel per step.
// ----------------------------------------------------------------------------
//  Channel  | Signals                              | Moves
//  ---------+--------------------------------------+-------------------------
//  input    | i_in_valid, o_in_ready, i_in_data    | load or step transaction
//  output   | o_out_valid, i_out_ready, o_out_data | one result per input
//
// Throughput is one transaction per clock while the output is not stalled;
// an accepted transaction passes through the input, setup, product and
// result registers before its result is valid.
// Edge values live in the scan core as running sums, so each pixel costs
// only three additions and a load costs one multiply stage.
// Reset clears every stage valid bit and the active flag; no clearing pass.
// A stalled output holds its stage; stages behind it keep filling bubbles,
// so input ready drops only when every stage holds a transaction.
// ----------------------------------------------------------------------------
module triangle_edge_rasterizer import tre_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Input register: captures every accepted transaction as it is.
    logic     r_in_valid;
    t_in_item r_in_item;

    // Handshake between the internal stages.
    logic     w_setup_ready;
    logic     w_setup_valid;
    t_setup   w_setup;
    logic     w_mult_ready;
    logic     w_mult_valid;
    t_prodset w_prod;
    logic     w_core_ready;

    // The input register is free when empty or when the setup stage takes
    // its contents in this cycle.
    assign o_in_ready = !r_in_valid || w_setup_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // Setup: bounding box, edge slopes and corner offsets, culling mask.
    tre_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (w_setup_ready),
        .i_item  (r_in_item),
        .o_valid (w_setup_valid),
        .o_setup (w_setup),
        .i_ready (w_mult_ready)
    );

    // Products for the edge values at the box corner and for the signed area.
    tre_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_setup_valid),
        .o_ready (w_mult_ready),
        .i_setup (w_setup),
        .o_valid (w_mult_valid),
        .o_prod  (w_prod),
        .i_ready (w_core_ready)
    );

    // Scan core: all triangle state is read and written here, in one stage,
    // so a step that directly follows a load already sees the new box.
    tre_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mult_valid),
        .o_ready (w_core_ready),
        .i_prod  (w_prod),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .i_ready (i_out_ready)
    );

endmodule
